/* hw/rtl/sad_pkg.sv */
// Shared types, constants and tables for the sphere arc distance pipeline.
// Used by sad_isqrt, sad_cordic and sphere_arc_distance_top; no dependencies.
package sad_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 34;
    localparam int CORDIC_STEPS = 28;
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_P1_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P1_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P1_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;

    localparam logic [31:0]        RADIUS_RESET = 32'd65536;
    localparam logic [31:0]        Q30_ONE      = 32'd1073741824;
    localparam logic signed [35:0] Q30_HALF_PI  = 36'sd1686629713;
    localparam logic signed [35:0] Q30_PI       = 36'sd3373259426;

    typedef struct packed {
        logic valid;
        logic last;
        logic degen;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] aux;
    } tag_t;

    // Truncated Q30 arctangent of 2^-i
    function automatic logic signed [35:0] atan_q30(input int i);
        case (i)
            0:       return 36'sd843314856;
            1:       return 36'sd497837829;
            2:       return 36'sd263043836;
            3:       return 36'sd133525158;
            4:       return 36'sd67021686;
            5:       return 36'sd33543515;
            6:       return 36'sd16775850;
            7:       return 36'sd8388437;
            8:       return 36'sd4194282;
            9:       return 36'sd2097149;
            default: return (36'sd1 <<< (30 - i)) - 36'sd1;
        endcase
    endfunction

endpackage

/* hw/rtl/sphere_arc_distance_top.sv */
// Sphere arc distance top level: config, normalize, divide, angle and scaling.
// Depends on sad_pkg, sad_isqrt and sad_cordic.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------------
//  s_       | in        | s_tvalid / s_tready | s_tdata: vertex x,y,z; s_tlast: last
//  m_       | out       | m_tvalid / m_tready | m_tdata: arc; m_tuser: degen; m_tlast
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One vertex enters per cycle and one result leaves per cycle while the output is
// not stalled. Most of the pipeline depth lies in the bit-per-stage square roots,
// the bit-per-stage divider and the CORDIC.
// Reset (aresetn low, synchronous) clears all valid bits and loads the register
// defaults. A stall on m_tready freezes every stage at once; nothing is lost.
module sphere_arc_distance_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic                          s_tlast,   // last_vertex
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // arc_distance
    output logic [0:0]                    m_tuser,   // degenerate
    output logic                          m_tlast,   // last_result
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [32:0] max3(input logic [32:0] p, input logic [32:0] q,
                                         input logic [32:0] r);
        logic [32:0] m;
        m = (p > q) ? p : q;
        return (m > r) ? m : r;
    endfunction

    function automatic logic [5:0] blen33(input logic [32:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) n = 6'(i + 1);
        end
        return n;
    endfunction

    function automatic logic [29:0] norm30(input logic [32:0] m, input logic [5:0] bl);
        logic [32:0] t;
        if (bl > 6'd30) t = m >> (bl - 6'd30);
        else            t = m << (6'd30 - bl);
        return t[29:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] p1_x_reg, p1_y_reg, p1_z_reg;
    logic [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic [31:0] radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_x_reg     <= '0;
            p1_y_reg     <= '0;
            p1_z_reg     <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= sad_pkg::RADIUS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sad_pkg::REG_P1_X:     p1_x_reg     <= cfg_data;
                sad_pkg::REG_P1_Y:     p1_y_reg     <= cfg_data;
                sad_pkg::REG_P1_Z:     p1_z_reg     <= cfg_data;
                sad_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                sad_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                sad_pkg::REG_CENTER_Z: center_z_reg <= cfg_data;
                sad_pkg::REG_RADIUS:   radius_reg   <= cfg_data;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output slot is free
    // ------------------------------------------------------------------
    logic m_tvalid_reg;
    logic adv;

    assign adv      = ~m_tvalid_reg | m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage 1: difference vectors a = O - P1, b = O - vertex
    // ------------------------------------------------------------------
    logic signed [31:0] vtx [3];
    logic signed [31:0] ctr [3];
    logic signed [31:0] p1  [3];

    assign vtx[0] = s_tdata[31:0];
    assign vtx[1] = s_tdata[63:32];
    assign vtx[2] = s_tdata[95:64];
    assign ctr[0] = center_x_reg;
    assign ctr[1] = center_y_reg;
    assign ctr[2] = center_z_reg;
    assign p1[0]  = p1_x_reg;
    assign p1[1]  = p1_y_reg;
    assign p1[2]  = p1_z_reg;

    sad_pkg::side_t     side1_reg;
    logic signed [32:0] a1_reg [3];
    logic signed [32:0] b1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
        end else if (adv) begin
            side1_reg.valid <= s_tvalid;
            side1_reg.last  <= s_tlast;
            side1_reg.degen <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                a1_reg[i] <= 33'(ctr[i]) - 33'(p1[i]);
                b1_reg[i] <= 33'(ctr[i]) - 33'(vtx[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes, signs and largest magnitude of each vector
    // ------------------------------------------------------------------
    sad_pkg::side_t side2_reg;
    logic [32:0]    am2_reg [3];
    logic [32:0]    bm2_reg [3];
    logic [2:0]     an2_reg, bn2_reg;
    logic [32:0]    amax2_reg, bmax2_reg;
    logic [32:0]    am1 [3];
    logic [32:0]    bm1 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            am1[i] = abs33(a1_reg[i]);
            bm1[i] = abs33(b1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side2_reg <= '0;
        end else if (adv) begin
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                am2_reg[i] <= am1[i];
                bm2_reg[i] <= bm1[i];
                an2_reg[i] <= a1_reg[i][32];
                bn2_reg[i] <= b1_reg[i][32];
            end
            amax2_reg <= max3(am1[0], am1[1], am1[2]);
            bmax2_reg <= max3(bm1[0], bm1[1], bm1[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: bit length of the largest magnitude; flag a zero vector
    // ------------------------------------------------------------------
    sad_pkg::side_t side3_reg;
    logic [32:0]    am3_reg [3];
    logic [32:0]    bm3_reg [3];
    logic [2:0]     an3_reg, bn3_reg;
    logic [5:0]     abl3_reg, bbl3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side3_reg <= '0;
        end else if (adv) begin
            side3_reg.valid <= side2_reg.valid;
            side3_reg.last  <= side2_reg.last;
            side3_reg.degen <= (amax2_reg == '0) | (bmax2_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            am3_reg  <= am2_reg;
            bm3_reg  <= bm2_reg;
            an3_reg  <= an2_reg;
            bn3_reg  <= bn2_reg;
            abl3_reg <= blen33(amax2_reg);
            bbl3_reg <= blen33(bmax2_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale each vector so its largest magnitude is in [2^29, 2^30)
    // ------------------------------------------------------------------
    sad_pkg::side_t side4_reg;
    logic [29:0]    ma4_reg [3];
    logic [29:0]    mb4_reg [3];
    logic [2:0]     an4_reg, bn4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side4_reg <= '0;
        end else if (adv) begin
            side4_reg <= side3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                ma4_reg[i] <= norm30(am3_reg[i], abl3_reg);
                mb4_reg[i] <= norm30(bm3_reg[i], bbl3_reg);
            end
            an4_reg <= an3_reg;
            bn4_reg <= bn3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: squares and dot-product terms
    // ------------------------------------------------------------------
    sad_pkg::side_t side5_reg;
    logic [59:0]    sqa5_reg [3];
    logic [59:0]    sqb5_reg [3];
    logic [59:0]    dp5_reg  [3];
    logic [2:0]     dneg5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side5_reg <= '0;
        end else if (adv) begin
            side5_reg <= side4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sqa5_reg[i] <= 60'(ma4_reg[i]) * 60'(ma4_reg[i]);
                sqb5_reg[i] <= 60'(mb4_reg[i]) * 60'(mb4_reg[i]);
                dp5_reg[i]  <= 60'(ma4_reg[i]) * 60'(mb4_reg[i]);
            end
            dneg5_reg <= an4_reg ^ bn4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: squared lengths and signed dot product
    // ------------------------------------------------------------------
    sad_pkg::side_t     side6_reg;
    logic [61:0]        na6_reg, nb6_reg;
    logic signed [63:0] dot6_reg;
    logic signed [63:0] dterm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dterm[i] = dneg5_reg[i] ? -$signed({4'b0, dp5_reg[i]})
                                    :  $signed({4'b0, dp5_reg[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side6_reg <= '0;
        end else if (adv) begin
            side6_reg <= side5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            na6_reg  <= 62'(sqa5_reg[0]) + 62'(sqa5_reg[1]) + 62'(sqa5_reg[2]);
            nb6_reg  <= 62'(sqb5_reg[0]) + 62'(sqb5_reg[1]) + 62'(sqb5_reg[2]);
            dot6_reg <= dterm[0] + dterm[1] + dterm[2];
        end
    end

    // ------------------------------------------------------------------
    // Vector lengths; the dot product rides along with the la root
    // ------------------------------------------------------------------
    sad_pkg::tag_t tag6;
    sad_pkg::tag_t tag7;
    logic [31:0]   la7, lb7;

    assign tag6 = {side6_reg, dot6_reg};

    sad_isqrt u_sqrt_la (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .n_i     ({2'b00, na6_reg}),
        .tag_i   (tag6),
        .root_o  (la7),
        .tag_o   (tag7)
    );

    sad_isqrt u_sqrt_lb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .n_i     ({2'b00, nb6_reg}),
        .tag_i   ('0),
        .root_o  (lb7),
        .tag_o   ()
    );

    // ------------------------------------------------------------------
    // Stage 8: product of the lengths
    // ------------------------------------------------------------------
    sad_pkg::side_t     side8_reg;
    logic [63:0]        prod8_reg;
    logic signed [63:0] dot8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side8_reg <= '0;
        end else if (adv) begin
            side8_reg <= tag7.side;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod8_reg <= 64'(la7) * 64'(lb7);
            dot8_reg  <= $signed(tag7.aux);
        end
    end

    // ------------------------------------------------------------------
    // Divider: |dot| / (la*lb >> 30), one quotient bit per stage
    // ------------------------------------------------------------------
    logic [63:0]                   drem_reg  [0:sad_pkg::DIV_STEPS];
    logic [31:0]                   dden_reg  [0:sad_pkg::DIV_STEPS];
    logic [sad_pkg::DIV_STEPS-1:0] dq_reg    [0:sad_pkg::DIV_STEPS];
    logic                          dneg_reg  [0:sad_pkg::DIV_STEPS];
    sad_pkg::side_t                dside_reg [0:sad_pkg::DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dside_reg[0] <= '0;
        end else if (adv) begin
            dside_reg[0] <= side8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            drem_reg[0] <= dot8_reg[63] ? 64'(-dot8_reg) : 64'(dot8_reg);
            dden_reg[0] <= prod8_reg[61:30];
            dq_reg[0]   <= '0;
            dneg_reg[0] <= dot8_reg[63];
        end
    end

    for (genvar j = 0; j < sad_pkg::DIV_STEPS; j++) begin : g_div
        localparam int SH = sad_pkg::DIV_STEPS - 1 - j;
        localparam logic [sad_pkg::DIV_STEPS-1:0] QBIT = {{(sad_pkg::DIV_STEPS-1){1'b0}}, 1'b1}
                                                         << SH;
        logic [65:0] trial;

        assign trial = 66'(dden_reg[j]) << SH;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dside_reg[j+1] <= '0;
            end else if (adv) begin
                dside_reg[j+1] <= dside_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dden_reg[j+1] <= dden_reg[j];
                dneg_reg[j+1] <= dneg_reg[j];
                if ({2'b00, drem_reg[j]} >= trial) begin
                    drem_reg[j+1] <= drem_reg[j] - trial[63:0];
                    dq_reg[j+1]   <= dq_reg[j] | QBIT;
                end else begin
                    drem_reg[j+1] <= drem_reg[j];
                    dq_reg[j+1]   <= dq_reg[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: clamp the cosine to [-1, 1] and restore its sign
    // ------------------------------------------------------------------
    sad_pkg::side_t     side9_reg;
    logic signed [31:0] c9_reg;
    logic [31:0]        qclamp;

    assign qclamp = (dq_reg[sad_pkg::DIV_STEPS] > sad_pkg::DIV_STEPS'(sad_pkg::Q30_ONE))
                  ? sad_pkg::Q30_ONE : dq_reg[sad_pkg::DIV_STEPS][31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side9_reg <= '0;
        end else if (adv) begin
            side9_reg <= dside_reg[sad_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c9_reg <= dneg_reg[sad_pkg::DIV_STEPS] ? -$signed(qclamp) : $signed(qclamp);
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: cosine squared, then sine by square root
    // ------------------------------------------------------------------
    sad_pkg::side_t     side10_reg;
    logic signed [31:0] c10_reg;
    logic signed [63:0] csq10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side10_reg <= '0;
        end else if (adv) begin
            side10_reg <= side9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c10_reg   <= c9_reg;
            csq10_reg <= 64'(c9_reg) * 64'(c9_reg);
        end
    end

    sad_pkg::tag_t tag10;
    sad_pkg::tag_t tag11;
    logic [31:0]   s11;
    logic [63:0]   sin_sq;

    assign sin_sq = (64'd1 << 60) - 64'(csq10_reg);
    assign tag10  = {side10_reg, 64'(c10_reg)};

    sad_isqrt u_sqrt_sin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .n_i     (sin_sq),
        .tag_i   (tag10),
        .root_o  (s11),
        .tag_o   (tag11)
    );

    // ------------------------------------------------------------------
    // Angle from (cos, sin)
    // ------------------------------------------------------------------
    logic [31:0]    theta12;
    sad_pkg::side_t side12;

    sad_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .x_i     ($signed(tag11.aux[35:0])),
        .y_i     ($signed(36'(s11))),
        .side_i  (tag11.side),
        .theta_o (theta12),
        .side_o  (side12)
    );

    // ------------------------------------------------------------------
    // Stage 13: scale the angle by the radius
    // ------------------------------------------------------------------
    sad_pkg::side_t side13_reg;
    logic [63:0]    prod13_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side13_reg <= '0;
        end else if (adv) begin
            side13_reg <= side12;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod13_reg <= 64'(theta12) * 64'(radius_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register: round half up, saturate, force zero on degenerate
    // ------------------------------------------------------------------
    logic [64:0] rounded;
    logic [31:0] arc_next;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    assign rounded = 65'(prod13_reg) + (65'd1 << 29);

    always_comb begin
        if (side13_reg.degen) begin
            arc_next = '0;
        end else if (rounded[64:62] != 3'b000) begin
            arc_next = '1;
        end else begin
            arc_next = rounded[61:30];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= side13_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= arc_next;
            m_tuser_reg <= side13_reg.degen;
            m_tlast_reg <= side13_reg.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

/* hw/rtl/sad_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a tag line.
// Depends on sad_pkg.
module sad_isqrt (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [63:0]   n_i,
    input  sad_pkg::tag_t tag_i,
    output logic [31:0]   root_o,
    output sad_pkg::tag_t tag_o
);

    logic [63:0]   rem_reg  [0:sad_pkg::SQRT_STEPS];
    logic [63:0]   root_reg [0:sad_pkg::SQRT_STEPS];
    sad_pkg::tag_t tag_reg  [0:sad_pkg::SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= tag_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= n_i;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < sad_pkg::SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;

        assign trial = root_reg[k] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k+1] <= '0;
            end else if (en) begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + BIT;
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    assign root_o = root_reg[sad_pkg::SQRT_STEPS][31:0];
    assign tag_o  = tag_reg[sad_pkg::SQRT_STEPS];

endmodule

/* hw/rtl/sad_cordic.sv */
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q30, clamped to [0, pi].
// Depends on sad_pkg.
module sad_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic signed [35:0]  x_i,
    input  logic signed [35:0]  y_i,
    input  sad_pkg::side_t      side_i,
    output logic [31:0]         theta_o,
    output sad_pkg::side_t      side_o
);

    logic signed [35:0] x_reg [0:sad_pkg::CORDIC_STEPS];
    logic signed [35:0] y_reg [0:sad_pkg::CORDIC_STEPS];
    logic signed [35:0] z_reg [0:sad_pkg::CORDIC_STEPS];
    sad_pkg::side_t     side_reg [0:sad_pkg::CORDIC_STEPS];
    logic [31:0]        theta_reg;
    sad_pkg::side_t     side_out_reg;

    // Rotate the left half plane by a quarter turn first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0] <= '0;
        end else if (en) begin
            side_reg[0] <= side_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_i[35]) begin
                x_reg[0] <= y_i;
                y_reg[0] <= -x_i;
                z_reg[0] <= sad_pkg::Q30_HALF_PI;
            end else begin
                x_reg[0] <= x_i;
                y_reg[0] <= y_i;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < sad_pkg::CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [35:0] ANGLE = sad_pkg::atan_q30(i);
        logic signed [35:0] xs;
        logic signed [35:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i+1] <= '0;
            end else if (en) begin
                side_reg[i+1] <= side_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i][35]) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ANGLE;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ANGLE;
                end
            end
        end
    end

    // Clamp the residual error to [0, pi]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_out_reg <= '0;
        end else if (en) begin
            side_out_reg <= side_reg[sad_pkg::CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (z_reg[sad_pkg::CORDIC_STEPS][35]) begin
                theta_reg <= '0;
            end else if (z_reg[sad_pkg::CORDIC_STEPS] > sad_pkg::Q30_PI) begin
                theta_reg <= sad_pkg::Q30_PI[31:0];
            end else begin
                theta_reg <= z_reg[sad_pkg::CORDIC_STEPS][31:0];
            end
        end
    end

    assign theta_o = theta_reg;
    assign side_o  = side_out_reg;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for sphere_arc_distance_top: directed table then random vertices,
// each result checked against its row or the predictor. Depends on sad_pkg and the RTL.
module tb;

    localparam int LATENCY   = 142;
    localparam int WATCH_MAX = 20000;
    localparam int N_RANDOM  = 1800;

    typedef struct packed {
        logic [31:0] arc;
        logic        degen;
        logic        last;
    } arc_result_t;

    typedef struct {
        logic [31:0] vx, vy, vz;
        logic        last;
        bit          typed;     // expected value given in the row
        arc_result_t want;
    } vertex_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [sad_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Shadow register file of the block
    logic [31:0] sh_p1 [3];
    logic [31:0] sh_ctr [3];
    logic [31:0] sh_radius;

    arc_result_t arc_expected [$];
    vertex_row_t vertex_table [$];
    int  errors = 0;
    int  n_results = 0;
    int  n_degen = 0;
    int  idle_cycles = 0;
    bit  sink_on = 1'b0;

    sphere_arc_distance_top u_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Normalize so the largest magnitude is in [2^29, 2^30); zero vector returns 0.
    function automatic bit normalize(input longint d [3], output longint o [3]);
        longint unsigned mag [3];
        longint unsigned m;
        int bl;
        m = 0;
        bl = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (d[i] < 0) ? -d[i] : d[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b0;
        while (m != 0) begin
            bl++;
            m >>= 1;
        end
        for (int i = 0; i < 3; i++) begin
            if (bl > 30) mag[i] >>= (bl - 30);
            else mag[i] <<= (30 - bl);
            o[i] = (d[i] < 0) ? -longint'(mag[i]) : longint'(mag[i]);
        end
        return 1'b1;
    endfunction

    function automatic longint angle_of(input longint y, input longint x);
        longint z, t, xs, ys, step;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(sad_pkg::Q30_HALF_PI);
        end
        for (int i = 0; i < sad_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step = longint'(sad_pkg::atan_q30(i));
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += step;
            end else begin
                x -= ys;
                y += xs;
                z -= step;
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(sad_pkg::Q30_PI)) z = longint'(sad_pkg::Q30_PI);
        return z;
    endfunction

    function automatic arc_result_t predict_arc(input logic [31:0] vx, vy, vz,
                                                input logic last);
        arc_result_t r;
        longint a [3], b [3], an [3], bn [3];
        logic [31:0] v [3];
        longint unsigned la, lb, den, s, prod, arc;
        longint dot, c, one;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        one = longint'(sad_pkg::Q30_ONE);
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(signed'(sh_ctr[i])) - longint'(signed'(sh_p1[i]));
            b[i] = longint'(signed'(sh_ctr[i])) - longint'(signed'(v[i]));
        end
        r.last = last;
        if (!normalize(a, an) || !normalize(b, bn)) begin
            r.arc = '0;
            r.degen = 1'b1;
            return r;
        end
        la = isqrt(an[0]*an[0] + an[1]*an[1] + an[2]*an[2]);
        lb = isqrt(bn[0]*bn[0] + bn[1]*bn[1] + bn[2]*bn[2]);
        dot = an[0]*bn[0] + an[1]*bn[1] + an[2]*bn[2];
        den = (la * lb) >> 30;
        c = dot / longint'(den);
        if (c > one) c = one;
        if (c < -one) c = -one;
        s = isqrt(one*one - c*c);
        prod = longint'(angle_of(longint'(s), c)) * longint'({32'd0, sh_radius});
        arc = (prod + (64'd1 << 29)) >> 30;
        r.arc = (arc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : arc[31:0];
        r.degen = 1'b0;
        return r;
    endfunction

    // ---------------- drivers ----------------
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold the write until it is taken; the caller drops cfg_valid after the last one.
    task automatic write_reg(input logic [sad_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == sad_pkg::REG_RADIUS) sh_radius = val;
        else if (idx <= sad_pkg::REG_P1_Z) sh_p1[idx] = val;
        else sh_ctr[idx - sad_pkg::REG_CENTER_X] = val;
    endtask

    // Pause until the pipeline has drained, then write the whole register set.
    task automatic load_setting(input logic [31:0] p [3], input logic [31:0] o [3],
                                input logic [31:0] rad);
        while (arc_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        write_reg(sad_pkg::REG_P1_X, p[0]);
        write_reg(sad_pkg::REG_P1_Y, p[1]);
        write_reg(sad_pkg::REG_P1_Z, p[2]);
        write_reg(sad_pkg::REG_CENTER_X, o[0]);
        write_reg(sad_pkg::REG_CENTER_Y, o[1]);
        write_reg(sad_pkg::REG_CENTER_Z, o[2]);
        write_reg(sad_pkg::REG_RADIUS, rad);
        cfg_valid <= 1'b0;
    endtask

    // Queue the expectation at the accepting edge, so the result can never race it.
    // s_tvalid stays high after the transaction; drop it only on a gap or at the end.
    task automatic send_vertex(input vertex_row_t row);
        arc_result_t want;
        int g;
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        want = row.typed ? row.want : predict_arc(row.vx, row.vy, row.vz, row.last);
        s_tvalid <= 1'b1;
        s_tdata  <= {row.vz, row.vy, row.vx};
        s_tlast  <= row.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        arc_expected.insert(arc_expected.size(), want);
    endtask

    task automatic table_add(input vertex_row_t r);
        vertex_table.insert(vertex_table.size(), r);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0:       return $urandom;
            1:       return $urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 8)) - 4);
            default: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sd524288);
        endcase
    endfunction

    function automatic vertex_row_t rand_vertex();
        vertex_row_t r;
        int mode;
        mode = $urandom_range(0, 3);
        r.vx = rand_coord(mode);
        r.vy = rand_coord(mode);
        r.vz = rand_coord(mode);
        // Land on the sphere origin now and then to hit the degenerate path.
        if ($urandom_range(0, 40) == 0) begin
            r.vx = sh_ctr[0];
            r.vy = sh_ctr[1];
            r.vz = sh_ctr[2];
        end
        r.last  = ($urandom_range(0, 15) == 0);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic vertex_row_t row(input logic [31:0] x, y, z, input logic l,
                                        input bit typed, input logic [31:0] arc,
                                        input logic dg);
        vertex_row_t r;
        r.vx = x;
        r.vy = y;
        r.vz = z;
        r.last = l;
        r.typed = typed;
        r.want = '{arc: arc, degen: dg, last: l};
        return r;
    endfunction

    // ---------------- result side ----------------
    always @(posedge aclk) begin
        arc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tuser[0]) n_degen++;
            if (arc_expected.size() == 0) begin
                $error("result with nothing pending: arc=%0d", m_tdata);
                errors++;
            end else begin
                want = arc_expected.pop_front();
                if (m_tdata !== want.arc) begin
                    $error("arc_distance: expected %0d, got %0d", want.arc, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.degen) begin
                    $error("degenerate: expected %0d, got %0d", want.degen, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_result: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Random back pressure with stall-free stretches.
    initial begin : sink
        int g;
        while (1) begin
            @(posedge aclk);
            if (!sink_on) begin
                m_tready <= 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: count cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin : stimulus
        logic [31:0] p [3], o [3];
        logic [31:0] zero3 [3];
        zero3 = '{32'd0, 32'd0, 32'd0};
        sh_p1 = zero3;
        sh_ctr = zero3;
        sh_radius = sad_pkg::RADIUS_RESET;

        // After reset P1 equals the origin, so every vertex is degenerate.
        table_add(row(32'd0, 32'd0, 32'd0, 1'b0, 1, 32'd0, 1'b1));
        table_add(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                      1, 32'd0, 1'b1));
        table_add(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
                      1, 32'd0, 1'b1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (vertex_table[i]) send_vertex(vertex_table[i]);
        s_tvalid <= 1'b0;

        // P1 on +x of a unit origin; same point, opposite point, right angles,
        // vertex on the origin, extreme coordinates. Radius unity.
        p = '{32'h0001_0000, 32'd0, 32'd0};
        load_setting(p, zero3, sad_pkg::RADIUS_RESET);
        vertex_table.delete();
        table_add(row(32'h0001_0000, 32'd0, 32'd0, 1'b0, 0, 0, 0));
        table_add(row(32'hFFFF_0000, 32'd0, 32'd0, 1'b0, 0, 0, 0));
        table_add(row(32'd0, 32'h0001_0000, 32'd0, 1'b0, 0, 0, 0));
        table_add(row(32'd0, 32'd0, 32'hFFFF_0000, 1'b1, 0, 0, 0));
        table_add(row(32'd0, 32'd0, 32'd0, 1'b0, 1, 32'd0, 1'b1));
        table_add(row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 0, 0));
        table_add(row(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b1, 0, 0, 0));
        table_add(row(32'h0000_0001, 32'd0, 32'd0, 1'b0, 0, 0, 0));
        foreach (vertex_table[i]) send_vertex(vertex_table[i]);
        s_tvalid <= 1'b0;

        // Maximum radius, with P1 and the origin at opposite extreme corners.
        p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        o = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        load_setting(p, o, 32'hFFFF_FFFF);
        sink_on = 1'b1;
        vertex_table.delete();
        table_add(row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                      1, 32'd0, 1'b1));
        table_add(row(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0, 0, 0));
        table_add(row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, 0, 0));
        table_add(row(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 0, 0));
        foreach (vertex_table[i]) send_vertex(vertex_table[i]);
        s_tvalid <= 1'b0;

        // Random phases, each with fresh registers; zero radius gives zero arc.
        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 3; k++) begin
                p[k] = rand_coord(ph % 4);
                o[k] = rand_coord((ph + 1) % 4);
            end
            load_setting(p, o, (ph == 2) ? 32'd0 : $urandom);
            for (int n = 0; n < N_RANDOM / 6; n++) send_vertex(rand_vertex());
            s_tvalid <= 1'b0;
        end

        while (arc_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        $display("Covered %0d results (%0d degenerate) over 9 register settings.",
                 n_results, n_degen);
        if (errors == 0 && arc_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
